// ===== src/wsus_pkg.sv =====
// Shared types, constants and helper functions of the waveform sample unpack/scale block.
// No dependencies; every other file but wsus_fifo imports this package.
`default_nettype none

package wsus_pkg;

    localparam int MAX_SAMPLE_BYTES     = 8;
    localparam int MAX_INT_SAMPLE_BYTES = 8;
    localparam int FLOAT_SAMPLE_BYTES   = 4;
    localparam int MID_DEPTH            = 4;
    localparam int OUT_DEPTH            = 2;

    localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
    localparam logic [31:0] ONE_FLOAT  = 32'h3F80_0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_BYTES_PER_SAMPLE = 3'd0,
        REG_MSB_FIRST        = 3'd1,
        REG_SAMPLE_FORMAT    = 3'd2,
        REG_Y_OFFSET         = 3'd3,
        REG_Y_MULTIPLIER     = 3'd4,
        REG_Y_ZERO           = 3'd5
    } t_cfg_idx;

    // sample format codes; bit 1 selects float
    typedef enum logic [1:0] {
        FMT_SIGNED   = 2'd0,
        FMT_UNSIGNED = 2'd1,
        FMT_FLOAT    = 2'd2,
        FMT_FLOAT_X  = 2'd3
    } t_fmt;

    // one completed raw sample handed from the front to the back
    typedef struct packed {
        logic [63:0] raw;
        logic [3:0]  nbytes;
        logic [1:0]  fmt;
    } t_sample;

    // count leading zeros of a 64-bit word, 64 for zero
    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        logic       found;
        n     = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && x[i]) begin
                n     = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

endpackage

`default_nettype wire

// ===== src/waveform_sample_unpack_scale.sv =====
// Top level of the waveform sample unpack/scale block: config registers, front, queues, back.
// Depends on wsus_pkg, wsus_fifo, wsus_front and wsus_back.
//
// Usage:
//   Input channel: drive i_data_byte with push; a byte is taken at a clock edge
//   where push is high and full is low. One byte per cycle is sustained while full stays low.
//   Result channel: while empty is low, o_scaled_value holds the oldest result;
//   pop high at a clock edge takes it. One result per completed sample.
//   Config channel: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready is
//   always high. Write only while no sample is in flight.
//   Path from the edge that takes the last byte of a sample to its result on
//   o_scaled_value: middle queue, 12 conversion and float stages, output queue.
//   Throughput: one byte per cycle while full is low; at most one result per cycle.
//   Reset (synchronous, active low) clears partial samples, queues and the config
//   registers to their defaults (scale 1.0, offset and zero 0.0).
//   When the receiver stalls, the output queue fills, the float pipeline holds,
//   then the middle queue fills and full rises; no result is dropped.
`default_nettype none

module waveform_sample_unpack_scale
    import wsus_pkg::*;
#(
    parameter int MAX_BYTES = MAX_SAMPLE_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_scaled_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [3:0]  r_bytes_per_sample;
    logic        r_msb_first;
    logic [1:0]  r_sample_format;
    logic [31:0] r_y_offset;
    logic [31:0] r_y_multiplier;
    logic [31:0] r_y_zero;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_sample <= 4'd1;
            r_msb_first        <= 1'b0;
            r_sample_format    <= FMT_SIGNED;
            r_y_offset         <= 32'd0;
            r_y_multiplier     <= ONE_FLOAT;
            r_y_zero           <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_BYTES_PER_SAMPLE: begin
                    r_bytes_per_sample <= i_cfg_data[3:0];
                end
                REG_MSB_FIRST: begin
                    r_msb_first <= i_cfg_data[0];
                end
                REG_SAMPLE_FORMAT: begin
                    r_sample_format <= i_cfg_data[1:0];
                end
                REG_Y_OFFSET: begin
                    r_y_offset <= i_cfg_data;
                end
                REG_Y_MULTIPLIER: begin
                    r_y_multiplier <= i_cfg_data;
                end
                REG_Y_ZERO: begin
                    r_y_zero <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // front: gather bytes
    logic    mid_push;
    logic    mid_full;
    logic    mid_empty;
    logic    mid_pop;
    t_sample front_sample;
    t_sample mid_sample;

    assign full = mid_full;

    wsus_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_data_byte        (i_data_byte),
        .i_q_full           (mid_full),
        .i_bytes_per_sample (r_bytes_per_sample),
        .i_msb_first        (r_msb_first),
        .i_sample_format    (r_sample_format),
        .o_q_push           (mid_push),
        .o_sample           (front_sample)
    );

    wsus_fifo #(
        .WIDTH ($bits(t_sample)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .o_full  (mid_full),
        .i_data  (front_sample),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_sample)
    );

    // back: convert and scale
    logic        out_push;
    logic        out_full;
    logic [31:0] back_value;

    wsus_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (mid_sample),
        .i_avail        (!mid_empty),
        .o_take         (mid_pop),
        .i_y_offset     (r_y_offset),
        .i_y_multiplier (r_y_multiplier),
        .i_y_zero       (r_y_zero),
        .i_out_full     (out_full),
        .o_push         (out_push),
        .o_value        (back_value)
    );

    wsus_fifo #(
        .WIDTH (32),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .o_full  (out_full),
        .i_data  (back_value),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_scaled_value)
    );

endmodule

`default_nettype wire

// ===== src/wsus_fifo.sv =====
// Small register queue with fill count, used between front and back and at the output.
// Depends on nothing but its parameters.
`default_nettype none

module wsus_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // store entries
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count beyond depth");
    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en && !wr_en |=> r_count == $past(r_count) - CW'(1))
        else $error("fifo pop did not drain an entry");
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> $stable(o_data))
        else $error("fifo head changed while waiting");
`endif

endmodule

`default_nettype wire

// ===== src/wsus_front.sv =====
// Front end: gathers bytes into a raw sample and hands completed samples to the queue.
// Depends on wsus_pkg.
`default_nettype none

module wsus_front
    import wsus_pkg::*;
#(
    parameter int MAX_BYTES = MAX_SAMPLE_BYTES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_q_full,
    input  wire logic [3:0] i_bytes_per_sample,
    input  wire logic       i_msb_first,
    input  wire logic [1:0] i_sample_format,
    output logic            o_q_push,
    output t_sample         o_sample
);

    localparam int GB = (MAX_BYTES > FLOAT_SAMPLE_BYTES) ? MAX_BYTES : FLOAT_SAMPLE_BYTES;
    localparam int GW = 8 * GB;
    localparam int CW = $clog2(GB);

    logic [GW-1:0] r_bits;
    logic [CW-1:0] r_cnt;
    logic [GW-1:0] n_bits;
    logic [CW:0]   cnt1;
    logic [3:0]    len;
    logic          done;
    logic          accept;

    // sample length in bytes
    always_comb begin
        if (i_sample_format[1]) begin
            len = 4'(FLOAT_SAMPLE_BYTES);
        end else if (i_bytes_per_sample == 4'd0) begin
            len = 4'd1;
        end else if (i_bytes_per_sample > 4'(MAX_BYTES)) begin
            len = 4'(MAX_BYTES);
        end else begin
            len = i_bytes_per_sample;
        end
    end

    // place the new byte
    always_comb begin
        if (i_msb_first) begin
            n_bits = {r_bits[GW-9:0], i_data_byte};
        end else begin
            n_bits = r_bits | (GW'(i_data_byte) << {r_cnt, 3'b000});
        end
    end

    assign cnt1     = {1'b0, r_cnt} + (CW + 1)'(1);
    assign done     = (5'(cnt1) >= 5'(len));
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept && done;
    assign o_sample = '{raw: 64'(n_bits), nbytes: len, fmt: i_sample_format};

    // hold partial sample, clear on completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
        end else if (accept) begin
            if (done) begin
                r_bits <= '0;
                r_cnt  <= '0;
            end else begin
                r_bits <= n_bits;
                r_cnt  <= CW'(cnt1);
            end
        end
    end

`ifndef SYNTHESIS
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> r_cnt == '0 && r_bits == '0)
        else $error("gather state not cleared after sample");
`endif

endmodule

`default_nettype wire

// ===== src/wsus_fadd.sv =====
// Three-stage single-precision adder, round to nearest even, canonical NaN out.
// Depends on wsus_pkg.
`default_nettype none

module wsus_fadd
    import wsus_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic [31:0]      o_res
);

    // stage A: order operands and align the smaller one
    logic [31:0] big;
    logic [31:0] sml;
    logic [23:0] mbig;
    logic [23:0] msml;
    logic [7:0]  ebig;
    logic [7:0]  dexp;
    logic [26:0] sml27;
    logic [26:0] shd;

    logic        r_a_sign, r_a_sub, r_a_nan, r_a_inf, r_a_infsign;
    logic [9:0]  r_a_exp;
    logic [26:0] r_a_mbig;
    logic [26:0] r_a_msml;

    always_comb begin
        if (i_b[30:0] > i_a[30:0]) begin
            big = i_b;
            sml = i_a;
        end else begin
            big = i_a;
            sml = i_b;
        end
        mbig  = {big[30:23] != 8'd0, big[22:0]};
        msml  = {sml[30:23] != 8'd0, sml[22:0]};
        ebig  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        dexp  = ebig - ((sml[30:23] == 8'd0) ? 8'd1 : sml[30:23]);
        sml27 = {msml, 3'b000};
        shd   = sml27 >> dexp;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sign    <= big[31];
            r_a_sub     <= i_a[31] ^ i_b[31];
            r_a_nan     <= is_nan(i_a) || is_nan(i_b)
                           || (is_inf(i_a) && is_inf(i_b) && (i_a[31] != i_b[31]));
            r_a_inf     <= is_inf(i_a) || is_inf(i_b);
            r_a_infsign <= is_inf(i_a) ? i_a[31] : i_b[31];
            r_a_exp     <= 10'(ebig);
            r_a_mbig    <= {mbig, 3'b000};
            r_a_msml    <= {shd[26:1], shd[0] | ((shd << dexp) != sml27)};
        end
    end

    // stage B: add or subtract magnitudes, count leading zeros
    logic [27:0] sum;

    logic        r_b_sign, r_b_nan, r_b_inf, r_b_infsign, r_b_zero;
    logic [9:0]  r_b_exp;
    logic [27:0] r_b_sum;
    logic [6:0]  r_b_lz;

    assign sum = r_a_sub ? ({1'b0, r_a_mbig} - {1'b0, r_a_msml})
                         : ({1'b0, r_a_mbig} + {1'b0, r_a_msml});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_zero    <= (sum == 28'd0);
            r_b_sign    <= (sum == 28'd0) ? (r_a_sign && !r_a_sub) : r_a_sign;
            r_b_nan     <= r_a_nan;
            r_b_inf     <= r_a_inf;
            r_b_infsign <= r_a_infsign;
            r_b_exp     <= r_a_exp;
            r_b_sum     <= sum;
            r_b_lz      <= lzc64({sum, 36'd0});
        end
    end

    // stage C: normalize, round and pack
    logic [26:0] m27;
    logic [9:0]  ee;
    logic [9:0]  sh;
    logic [9:0]  lim;
    logic        inc;
    logic [30:0] pk;
    logic [31:0] n_res;

    always_comb begin
        lim = r_b_exp - 10'd1;
        sh  = 10'(r_b_lz) - 10'd1;
        if (r_b_sum[27]) begin
            m27 = {r_b_sum[27:2], r_b_sum[1] | r_b_sum[0]};
            ee  = r_b_exp + 10'd1;
        end else begin
            if (sh > lim) begin
                sh = lim;
            end
            m27 = r_b_sum[26:0] << sh;
            ee  = r_b_exp - sh;
        end
        inc = m27[2] && (m27[1] || m27[0] || m27[3]);
        pk  = {ee[7:0] & {8{m27[26]}}, m27[25:3]} + 31'(inc);
        if (r_b_nan) begin
            n_res = CANON_NAN;
        end else if (r_b_inf) begin
            n_res = {r_b_infsign, 8'hFF, 23'd0};
        end else if (r_b_zero) begin
            n_res = {r_b_sign, 31'd0};
        end else if (ee >= 10'd255) begin
            n_res = {r_b_sign, 8'hFF, 23'd0};
        end else begin
            n_res = {r_b_sign, pk};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== src/wsus_fmul.sv =====
// Three-stage single-precision multiplier, round to nearest even, canonical NaN out.
// Depends on wsus_pkg.
`default_nettype none

module wsus_fmul
    import wsus_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic [31:0]      o_res
);

    // stage A: unpack and multiply significands
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic               a_zero;
    logic               b_zero;

    logic               r_a_sign, r_a_nan, r_a_inf, r_a_zero;
    logic signed [10:0] r_a_e0;
    logic [47:0]        r_a_p;

    assign ma     = {i_a[30:23] != 8'd0, i_a[22:0]};
    assign mb     = {i_b[30:23] != 8'd0, i_b[22:0]};
    assign a_zero = (i_a[30:0] == 31'd0);
    assign b_zero = (i_b[30:0] == 31'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sign <= i_a[31] ^ i_b[31];
            r_a_nan  <= is_nan(i_a) || is_nan(i_b)
                        || (is_inf(i_a) && b_zero) || (is_inf(i_b) && a_zero);
            r_a_inf  <= is_inf(i_a) || is_inf(i_b);
            r_a_zero <= a_zero || b_zero;
            r_a_e0   <= $signed(11'((i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23]))
                        + $signed(11'((i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23]))
                        - 11'sd126;
            r_a_p    <= ma * mb;
        end
    end

    // stage B: leading zeros and shift plan
    logic [6:0]         lz;
    logic signed [10:0] e1;

    logic               r_b_sign, r_b_nan, r_b_inf, r_b_zero;
    logic signed [10:0] r_b_e;
    logic signed [10:0] r_b_sh;
    logic [47:0]        r_b_p;

    assign lz = lzc64({r_a_p, 16'd0});
    assign e1 = r_a_e0 - $signed(11'(lz));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_sign <= r_a_sign;
            r_b_nan  <= r_a_nan;
            r_b_inf  <= r_a_inf;
            r_b_zero <= r_a_zero;
            r_b_p    <= r_a_p;
            if (e1 >= 11'sd1) begin
                r_b_e  <= e1;
                r_b_sh <= $signed(11'(lz));
            end else begin
                r_b_e  <= 11'sd1;
                r_b_sh <= r_a_e0 - 11'sd1;
            end
        end
    end

    // stage C: shift, round and pack
    logic [47:0] q;
    logic [10:0] rsh;
    logic        stk;
    logic        inc;
    logic [30:0] pk;
    logic [31:0] n_res;

    always_comb begin
        rsh = 11'(-r_b_sh);
        if (!r_b_sh[10]) begin
            q   = r_b_p << r_b_sh[5:0];
            stk = 1'b0;
        end else begin
            q   = r_b_p >> rsh;
            stk = ((q << rsh) != r_b_p);
        end
        inc = q[23] && ((q[22:0] != 23'd0) || stk || q[24]);
        pk  = {r_b_e[7:0] & {8{q[47]}}, q[46:24]} + 31'(inc);
        if (r_b_nan) begin
            n_res = CANON_NAN;
        end else if (r_b_inf) begin
            n_res = {r_b_sign, 8'hFF, 23'd0};
        end else if (r_b_zero) begin
            n_res = {r_b_sign, 31'd0};
        end else if (r_b_e >= 11'sd255) begin
            n_res = {r_b_sign, 8'hFF, 23'd0};
        end else begin
            n_res = {r_b_sign, pk};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== src/wsus_back.sv =====
// Back end: converts raw samples to single precision and applies offset, scale and zero.
// Depends on wsus_pkg, wsus_fadd and wsus_fmul.
`default_nettype none

module wsus_back
    import wsus_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_sample     i_sample,
    input  wire logic        i_avail,
    output logic             o_take,
    input  wire logic [31:0] i_y_offset,
    input  wire logic [31:0] i_y_multiplier,
    input  wire logic [31:0] i_y_zero,
    input  wire logic        i_out_full,
    output logic             o_push,
    output logic [31:0]      o_value
);

    localparam int NSTAGE = 12;

    logic [NSTAGE-1:0] r_vld;
    logic              adv;

    // stall only when the last stage cannot drain
    assign adv    = !(r_vld[NSTAGE-1] && i_out_full);
    assign o_take = adv && i_avail;
    assign o_push = adv && r_vld[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTAGE-2:0], o_take};
        end
    end

    // stage 1: mask sample, take magnitude and sign
    logic [63:0] mask;
    logic [63:0] v;
    logic [6:0]  sidx;
    logic [63:0] n_mag;
    logic        n_neg;

    logic [63:0] r_c1_mag;
    logic        r_c1_neg;
    logic        r_c1_flt;

    always_comb begin
        mask = ~({64{1'b1}} << {i_sample.nbytes, 3'b000});
        v    = i_sample.raw & mask;
        sidx = 7'({i_sample.nbytes, 3'b000}) - 7'd1;
        if (i_sample.fmt[1]) begin
            n_mag = {32'd0, v[31:0]};
            n_neg = 1'b0;
        end else if (i_sample.fmt[0] || !v[sidx[5:0]]) begin
            n_mag = v;
            n_neg = 1'b0;
        end else begin
            n_mag = ~(v | ~mask) + 64'd1;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1_mag <= n_mag;
            r_c1_neg <= n_neg;
            r_c1_flt <= i_sample.fmt[1];
        end
    end

    // stage 2: leading zero count
    logic [63:0] r_c2_mag;
    logic        r_c2_neg;
    logic        r_c2_flt;
    logic [6:0]  r_c2_lz;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c2_mag <= r_c1_mag;
            r_c2_neg <= r_c1_neg;
            r_c2_flt <= r_c1_flt;
            r_c2_lz  <= lzc64(r_c1_mag);
        end
    end

    // stage 3: normalize and round to single, or pass a float sample through
    logic [63:0] q;
    logic [7:0]  ex;
    logic        inc;
    logic [30:0] pk;
    logic [31:0] r_c3_val;

    always_comb begin
        q   = r_c2_mag << r_c2_lz[5:0];
        ex  = 8'd190 - 8'(r_c2_lz);
        inc = q[39] && ((q[38:0] != 39'd0) || q[40]);
        pk  = {ex, q[62:40]} + 31'(inc);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_c2_flt) begin
                r_c3_val <= r_c2_mag[31:0];
            end else if (r_c2_mag == 64'd0) begin
                r_c3_val <= 32'd0;
            end else begin
                r_c3_val <= {r_c2_neg, pk};
            end
        end
    end

    // offset, scale, zero
    logic [31:0] diff;
    logic [31:0] prod;

    wsus_fadd u_sub (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (r_c3_val),
        .i_b   ({~i_y_offset[31], i_y_offset[30:0]}),
        .o_res (diff)
    );

    wsus_fmul u_mul (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (diff),
        .i_b   (i_y_multiplier),
        .o_res (prod)
    );

    wsus_fadd u_add (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_a   (prod),
        .i_b   (i_y_zero),
        .o_res (o_value)
    );

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTAGE-1] && i_out_full |=> r_vld[NSTAGE-1] && $stable(o_value))
        else $error("result lost while output queue full");
`endif

endmodule

`default_nettype wire

// ===== test/wsus_checker.sv =====
// Checker for waveform_sample_unpack_scale: watches the byte, result and register channels,
// predicts every scaled sample with its own bit-exact float arithmetic and compares.
// Depends on wsus_pkg for the register indexes, format codes and constants.
module wsus_checker
    import wsus_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [31:0] i_scaled_value,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [3:0]  bytes_per_sample;
    logic        msb_first;
    logic [1:0]  sample_format;
    logic [31:0] y_offset;
    logic [31:0] y_multiplier;
    logic [31:0] y_zero;

    // partial sample
    logic [2:0]  held_bytes;
    logic [63:0] held_bits;

    logic [31:0] scaled_q[$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    // round mag * 2^e to single precision, nearest even
    function automatic logic [31:0] fp_round(input logic sgn, input logic [319:0] mag,
                                             input int e);
        int          p;
        int          w;
        int          sh;
        int          biased;
        logic [319:0] m;
        logic        guard;
        logic        sticky;
        if (mag == '0) return {sgn, 31'd0};
        p = 0;
        for (int i = 0; i < 320; i++) if (mag[i]) p = i;
        w = p + e - 23;
        if (w < -149) w = -149;
        sh = w - e;
        if (sh <= 0) begin
            m = mag << (-sh);
        end else begin
            m      = mag >> sh;
            guard  = mag[sh-1];
            sticky = |(mag & ((320'd1 << (sh - 1)) - 320'd1));
            if (guard && (sticky || m[0])) m = m + 320'd1;
        end
        if (m[24]) begin
            m = m >> 1;
            w++;
        end
        biased = m[23] ? w + 150 : 0;
        if (biased >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(biased), m[22:0]};
    endfunction

    function automatic logic fp_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic fp_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    // split a finite float into mantissa and exponent of its lowest bit
    function automatic void fp_split(input logic [31:0] f, output logic [23:0] man,
                                     output int e);
        if (f[30:23] == 8'd0) begin
            man = {1'b0, f[22:0]};
            e   = -149;
        end else begin
            man = {1'b1, f[22:0]};
            e   = int'(f[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [23:0]  ma;
        logic [23:0]  mb;
        int           ea;
        int           eb;
        int           emin;
        logic [319:0] wa;
        logic [319:0] wb;
        if (fp_nan(a) || fp_nan(b)) return CANON_NAN;
        if (fp_inf(a) && fp_inf(b) && (a[31] != b[31])) return CANON_NAN;
        if (fp_inf(a)) return a;
        if (fp_inf(b)) return b;
        if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'd0};
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        emin = (ea < eb) ? ea : eb;
        wa   = 320'(ma) << (ea - emin);
        wb   = 320'(mb) << (eb - emin);
        if (a[31] == b[31]) return fp_round(a[31], wa + wb, emin);
        if (wa > wb) return fp_round(a[31], wa - wb, emin);
        if (wb > wa) return fp_round(b[31], wb - wa, emin);
        return 32'd0;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [23:0] ma;
        logic [23:0] mb;
        int          ea;
        int          eb;
        if (fp_nan(a) || fp_nan(b)) return CANON_NAN;
        if (fp_inf(a) || fp_inf(b)) begin
            if (a[30:0] == '0 || b[30:0] == '0) return CANON_NAN;
            return {a[31] ^ b[31], 8'hFF, 23'd0};
        end
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        return fp_round(a[31] ^ b[31], 320'(ma) * 320'(mb), ea + eb);
    endfunction

    // bytes making up one sample under the current registers
    function automatic int sample_len();
        if (sample_format == FMT_FLOAT || sample_format == FMT_FLOAT_X)
            return FLOAT_SAMPLE_BYTES;
        if (bytes_per_sample == 4'd0) return 1;
        if (bytes_per_sample > MAX_SAMPLE_BYTES) return MAX_SAMPLE_BYTES;
        return int'(bytes_per_sample);
    endfunction

    // raw sample to float, then offset, scale and shift
    function automatic logic [31:0] scale_sample(input logic [63:0] raw, input int n);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic [31:0] s;
        logic [31:0] r;
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        v    = raw & mask;
        mag  = ~(v | ~mask) + 64'd1;
        if (sample_format == FMT_FLOAT || sample_format == FMT_FLOAT_X)
            s = v[31:0];
        else if (sample_format == FMT_UNSIGNED || !v[8*n-1])
            s = fp_round(1'b0, 320'(v), 0);
        else
            s = fp_round(1'b1, 320'(mag), 0);
        r = fp_add(s, {~y_offset[31], y_offset[30:0]});
        r = fp_mul(r, y_multiplier);
        r = fp_add(r, y_zero);
        return fp_nan(r) ? CANON_NAN : r;
    endfunction

    always @(posedge i_clk) begin
        int          k;
        int          n;
        logic [31:0] want;
        if (!i_rst_n) begin
            bytes_per_sample <= 4'd1;
            msb_first        <= 1'b0;
            sample_format    <= FMT_SIGNED;
            y_offset         <= 32'd0;
            y_multiplier     <= ONE_FLOAT;
            y_zero           <= 32'd0;
            held_bytes       = 3'd0;
            held_bits        = 64'd0;
            scaled_q.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_BYTES_PER_SAMPLE: bytes_per_sample <= i_cfg_data[3:0];
                    REG_MSB_FIRST:        msb_first        <= i_cfg_data[0];
                    REG_SAMPLE_FORMAT:    sample_format    <= i_cfg_data[1:0];
                    REG_Y_OFFSET:         y_offset         <= i_cfg_data;
                    REG_Y_MULTIPLIER:     y_multiplier     <= i_cfg_data;
                    REG_Y_ZERO:           y_zero           <= i_cfg_data;
                    default: ;
                endcase
            end
            // gather the byte, complete a sample when enough are held
            if (i_push && !i_full) begin
                k = int'(held_bytes);
                n = sample_len();
                if (msb_first)
                    held_bits = {held_bits[55:0], i_data_byte};
                else
                    held_bits = held_bits | (64'(i_data_byte) << (8 * k));
                k++;
                if (k < n) begin
                    held_bytes = 3'(k);
                end else begin
                    scaled_q.push_back(scale_sample(held_bits, n));
                    held_bits  = 64'd0;
                    held_bytes = 3'd0;
                end
            end
            // compare the popped result with the oldest prediction
            if (i_pop && !i_empty) begin
                if (scaled_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %h", i_scaled_value);
                    mismatches++;
                end else begin
                    want = scaled_q.pop_front();
                    if (want !== i_scaled_value) begin
                        if (mismatches < 10)
                            $display("scaled_value mismatch: expected %h actual %h",
                                     want, i_scaled_value);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= scaled_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for waveform_sample_unpack_scale: drives bytes, register writes and pops
// with random idling; wsus_checker predicts and compares. Depends on wsus_pkg and the RTL.
module tb_top;
    import wsus_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        pop = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = REG_BYTES_PER_SAMPLE;
    logic [31:0] i_cfg_data = 32'd0;
    wire         full;
    wire         empty;
    wire         o_cfg_ready;
    wire  [31:0] o_scaled_value;
    int          pending;
    int          fail_count;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;

    waveform_sample_unpack_scale u_top (.*);

    wsus_checker u_checker (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full), .i_data_byte,
        .i_empty(empty), .i_pop(pop), .i_scaled_value(o_scaled_value),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // pop side: idle at random, hold off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // write one register; keep valid high unless this is the last write
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value, input bit last);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (last) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // offer one byte until taken, then idle at random
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_data_byte <= b;
        push        <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap  = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop push, wait for all results, then let the pipeline settle
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_float();
        case ($urandom_range(0, 6))
            0: return $urandom();
            1: return {1'($urandom_range(0, 1)), 8'($urandom_range(118, 136)),
                       23'($urandom())};
            2: return {1'($urandom_range(0, 1)), 31'd0};
            3: return ONE_FLOAT;
            4: case ($urandom_range(0, 3))
                   0: return 32'h7F80_0000;
                   1: return 32'hFF80_0000;
                   2: return 32'h7FC0_0001;
                   default: return 32'h7F7F_FFFF;
               endcase
            5: return {1'($urandom_range(0, 1)), 8'd0, 23'($urandom())};
            default: return {1'($urandom_range(0, 1)), 8'($urandom_range(60, 190)),
                             23'($urandom())};
        endcase
    endfunction

    initial begin
        int nbytes;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default setup: one signed byte per sample, extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        drain();

        // eight bytes, most significant first: most negative and largest unsigned
        write_reg(REG_BYTES_PER_SAMPLE, 32'd8, 1'b0);
        write_reg(REG_MSB_FIRST, 32'd1, 1'b1);
        send_byte(8'h80);
        repeat (7) send_byte(8'h00);
        drain();
        write_reg(REG_SAMPLE_FORMAT, FMT_UNSIGNED, 1'b1);
        repeat (8) send_byte(8'hFF);
        drain();

        // undefined format code reads float, least significant byte first, NaN input
        write_reg(REG_SAMPLE_FORMAT, FMT_FLOAT_X, 1'b0);
        write_reg(REG_MSB_FIRST, 32'd0, 1'b1);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h7F);
        drain();

        // length shrinks while three bytes are held; next byte completes the sample
        write_reg(REG_SAMPLE_FORMAT, FMT_SIGNED, 1'b0);
        write_reg(REG_BYTES_PER_SAMPLE, 32'd4, 1'b1);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'hF6);
        drain();
        write_reg(REG_BYTES_PER_SAMPLE, 32'd2, 1'b1);
        send_byte(8'h78);
        drain();

        // zero and oversized byte counts, with scaling registers set
        write_reg(REG_BYTES_PER_SAMPLE, 32'd0, 1'b0);
        write_reg(REG_Y_OFFSET, 32'h3F00_0000, 1'b0);
        write_reg(REG_Y_MULTIPLIER, 32'hC020_0000, 1'b0);
        write_reg(REG_Y_ZERO, 32'h4120_0000, 1'b1);
        send_byte(8'h55);
        send_byte(8'hAA);
        drain();
        write_reg(REG_BYTES_PER_SAMPLE, 32'd15, 1'b1);
        repeat (3) send_byte(8'($urandom()));
        drain();

        // random phases over three idling modes
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 79 : 0;
            rx_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 12 : 0;
            for (int ph = 0; ph < 5; ph++) begin
                write_reg(REG_BYTES_PER_SAMPLE,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(1, 8), 1'b0);
                write_reg(REG_MSB_FIRST, $urandom_range(0, 1), 1'b0);
                write_reg(REG_SAMPLE_FORMAT, $urandom_range(0, 3), 1'b0);
                write_reg(REG_Y_OFFSET, pick_float(), 1'b0);
                write_reg(REG_Y_MULTIPLIER, pick_float(), 1'b0);
                write_reg(REG_Y_ZERO, pick_float(), 1'b1);
                // long receiver hold-off while bytes keep coming
                if (mode == 2 && ph == 0) begin
                    write_reg(REG_BYTES_PER_SAMPLE, 32'd1, 1'b1);
                    fork
                        begin
                            rx_hold = 1'b1;
                            repeat (300) @(posedge i_clk);
                            rx_hold = 1'b0;
                        end
                    join_none
                end
                nbytes = $urandom_range(80, 100);
                repeat (nbytes) send_byte(8'($urandom()));
                drain();
            end
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
